### rtl/core/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants for the frame-rate statistics window.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int SUM_WIDTH    = 31;
   localparam int FPS_WIDTH    = 14;
   localparam int OUT_WIDTH    = 15;
   localparam int PERIOD_WIDTH = 20;

   localparam logic [FPS_WIDTH-1:0]    FPS_LIMIT    = 14'd10000;
   localparam logic [PERIOD_WIDTH-1:0] MIN_PERIOD   = 20'd100;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 20'd10000;
   localparam logic signed [OUT_WIDTH-1:0] DEFAULT_MIN = 15'sd60;
   localparam logic signed [OUT_WIDTH-1:0] DEFAULT_MAX = -15'sd1;
   localparam logic signed [OUT_WIDTH-1:0] NO_AVG      = -15'sd1;
   localparam logic signed [OUT_WIDTH-1:0] NO_SAMPLE   = -15'sd1;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_START  = 2'd2,
      REQ_STOP   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_ACCEPT   = 2'd0,
      KIND_REJECT   = 2'd1,
      KIND_PERIODIC = 2'd2,
      KIND_FINAL    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/core/frame_rate_statistics_window.sv
// ----------------------------------------------------------------------------
// frame_rate_statistics_window
// Running min, max, sum and count of frame-rate samples with periodic and
// final reports.
// ----------------------------------------------------------------------------
// One word is taken at a time. Samples, start, stop without a report and
// ticks that do not end the period do not use the divider; a result, when
// they give one, goes to the result register and then to the output
// register once the output slot is free. A report that needs an average
// also runs the bit-serial divider, one quotient bit per cycle over the
// 31-bit sum: the quotient goes to the result register when the divider
// is done, then to the output register; no new word is taken before that
// load. A new word is accepted while a finished result waits on rsp_ready.
module frame_rate_statistics_window import frs_pkg::*; #(
   parameter int TIMER_WIDTH = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [FPS_WIDTH-1:0]        req_fps_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_result_kind,
   output logic signed [OUT_WIDTH-1:0] rsp_avg_fps,
   output logic signed [OUT_WIDTH-1:0] rsp_min_fps,
   output logic signed [OUT_WIDTH-1:0] rsp_max_fps,
   input  logic                        csr_wr_en,
   input  logic [PERIOD_WIDTH-1:0]     csr_wr_data
);

   localparam int CMP_WIDTH = (TIMER_WIDTH > PERIOD_WIDTH) ? TIMER_WIDTH : PERIOD_WIDTH;

   state_type state_ff, state_in;

   logic [PERIOD_WIDTH-1:0]     period_ff;
   logic [SUM_WIDTH-1:0]        sum_ff, sum_in;
   logic [SUM_WIDTH-1:0]        count_ff, count_in;
   logic signed [OUT_WIDTH-1:0] min_ff, min_in;
   logic signed [OUT_WIDTH-1:0] max_ff, max_in;
   logic signed [OUT_WIDTH-1:0] last_ff, last_in;
   logic                        collecting_ff, collecting_in;
   logic [TIMER_WIDTH-1:0]      elapsed_ff, elapsed_in;

   kind_type                    res_kind_ff, res_kind_in;
   logic signed [OUT_WIDTH-1:0] res_avg_ff, res_avg_in;
   logic signed [OUT_WIDTH-1:0] res_min_ff, res_min_in;
   logic signed [OUT_WIDTH-1:0] res_max_ff, res_max_in;

   logic                        rsp_valid_ff;
   kind_type                    rsp_kind_ff;
   logic signed [OUT_WIDTH-1:0] rsp_avg_ff, rsp_min_ff, rsp_max_ff;

   logic                        accept;
   logic                        has_result;
   logic                        need_div;
   logic                        slot_free;
   logic                        load_out;
   logic                        div_start;
   logic [SUM_WIDTH:0]          sum_ext;
   logic [SUM_WIDTH:0]          guard_ext;
   logic signed [OUT_WIDTH-1:0] v_s;
   logic [SUM_WIDTH-1:0]        v_w;
   logic [TIMER_WIDTH-1:0]      el_next;
   logic [PERIOD_WIDTH-1:0]     period_eff;
   logic [SUM_WIDTH-1:0]        quotient;
   div_status_type              div_st;

   frs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (quotient),
      .status   (div_st)
   );

   // window update on an accepted word, quotient capture when the divider is done
   always_comb begin
      v_s        = signed'({1'b0, req_fps_value});
      v_w        = SUM_WIDTH'(req_fps_value);
      sum_ext    = {1'b0, sum_ff} + {1'b0, v_w};
      guard_ext  = {1'b0, sum_ff} + {1'b0, count_ff};
      el_next    = elapsed_ff + 1'b1;
      period_eff = (period_ff < MIN_PERIOD) ? MIN_PERIOD : period_ff;

      sum_in        = sum_ff;
      count_in      = count_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      last_in       = last_ff;
      collecting_in = collecting_ff;
      elapsed_in    = elapsed_ff;
      res_kind_in   = res_kind_ff;
      res_avg_in    = res_avg_ff;
      res_min_in    = res_min_ff;
      res_max_in    = res_max_ff;
      has_result    = 1'b0;
      need_div      = 1'b0;

      if (accept) begin
         unique case (req_code_type'(req_type))
            REQ_SAMPLE: begin
               has_result  = 1'b1;
               res_avg_in  = '0;
               res_min_in  = '0;
               res_max_in  = '0;
               if (req_fps_value > FPS_LIMIT) begin
                  res_kind_in = KIND_REJECT;
               end else begin
                  res_kind_in = KIND_ACCEPT;
                  last_in     = v_s;
                  if (sum_ext[SUM_WIDTH]) begin
                     sum_in   = v_w;
                     count_in = SUM_WIDTH'(1);
                     min_in   = v_s;
                     max_in   = v_s;
                  end else begin
                     sum_in = sum_ext[SUM_WIDTH-1:0];
                     if (v_s > max_ff) max_in = v_s;
                     if (v_s < min_ff) min_in = v_s;
                     if (count_ff != '1) count_in = count_ff + 1'b1;
                  end
               end
            end
            REQ_TICK: begin
               if (collecting_ff) begin
                  elapsed_in = el_next;
                  if (CMP_WIDTH'(el_next) >= CMP_WIDTH'(period_eff)) begin
                     elapsed_in  = '0;
                     has_result  = 1'b1;
                     res_kind_in = KIND_PERIODIC;
                     if (count_ff != '0) begin
                        need_div   = 1'b1;
                        res_min_in = min_ff;
                        res_max_in = max_ff;
                     end else begin
                        res_avg_in = NO_AVG;
                        res_min_in = DEFAULT_MIN;
                        res_max_in = DEFAULT_MAX;
                     end
                     if (!last_ff[OUT_WIDTH-1]) begin
                        sum_in   = {{(SUM_WIDTH-OUT_WIDTH){1'b0}}, last_ff};
                        count_in = SUM_WIDTH'(1);
                        min_in   = last_ff;
                        max_in   = last_ff;
                     end else begin
                        sum_in   = '0;
                        count_in = '0;
                        min_in   = DEFAULT_MIN;
                        max_in   = DEFAULT_MAX;
                     end
                  end
               end
            end
            REQ_START: begin
               sum_in        = '0;
               count_in      = '0;
               min_in        = DEFAULT_MIN;
               max_in        = DEFAULT_MAX;
               last_in       = NO_SAMPLE;
               elapsed_in    = '0;
               collecting_in = 1'b1;
            end
            REQ_STOP: begin
               collecting_in = 1'b0;
               elapsed_in    = '0;
               if (collecting_ff && count_ff != '0) begin
                  has_result  = 1'b1;
                  res_kind_in = KIND_FINAL;
                  res_min_in  = min_ff;
                  res_max_in  = max_ff;
                  if (guard_ext[SUM_WIDTH]) begin
                     res_avg_in = NO_AVG;
                  end else begin
                     need_div = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (div_st.done) res_avg_in = quotient[OUT_WIDTH-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && need_div) state_in = ST_DIVIDE;
            else if (accept && has_result) state_in = ST_LOAD;
         end
         ST_DIVIDE: begin
            if (div_st.done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DIVIDE: req_ready = 1'b0;
         ST_LOAD:   load_out  = slot_free;
         default:   req_ready = 1'b0;
      endcase
      accept    = req_valid && req_ready;
      div_start = accept && need_div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         period_ff     <= PERIOD_RESET;
         sum_ff        <= '0;
         count_ff      <= '0;
         min_ff        <= DEFAULT_MIN;
         max_ff        <= DEFAULT_MAX;
         last_ff       <= '0;
         collecting_ff <= 1'b0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         last_ff       <= last_in;
         collecting_ff <= collecting_in;
         elapsed_ff    <= elapsed_in;
         if (csr_wr_en) period_ff <= csr_wr_data;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      res_kind_ff <= res_kind_in;
      res_avg_ff  <= res_avg_in;
      res_min_ff  <= res_min_in;
      res_max_ff  <= res_max_in;
      if (load_out) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_avg_ff  <= res_avg_ff;
         rsp_min_ff  <= res_min_ff;
         rsp_max_ff  <= res_max_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_avg_fps     = rsp_avg_ff;
   assign rsp_min_fps     = rsp_min_ff;
   assign rsp_max_fps     = rsp_max_ff;

   a_div_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_st.busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside divide state");

   a_empty_window_sum: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> sum_ff == '0)
      else $error("empty window with nonzero sum");

   a_timer_idle: assert property (@(posedge clock) disable iff (reset)
      !collecting_ff |-> elapsed_ff == '0)
      else $error("period timer running while not collecting");

   a_done_to_load: assert property (@(posedge clock) disable iff (reset)
      div_st.done |=> state_ff == ST_LOAD)
      else $error("division result not handed to output");

endmodule

### rtl/core/frs_divider.sv
// ----------------------------------------------------------------------------
// frs_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frs_divider import frs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_WIDTH-1:0] dividend,
   input  logic [SUM_WIDTH-1:0] divisor,
   output logic [SUM_WIDTH-1:0] quotient,
   output div_status_type       status
);

   localparam int CNT_WIDTH = $clog2(SUM_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] step_ff, step_in;
   logic [SUM_WIDTH-1:0] quo_ff, quo_in;
   logic [SUM_WIDTH-1:0] rem_ff, rem_in;
   logic [SUM_WIDTH-1:0] dsr_ff, dsr_in;
   logic [SUM_WIDTH:0]   trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_WIDTH-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = CNT_WIDTH'(SUM_WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_WIDTH-2:0], fits};
         rem_in = fits ? SUM_WIDTH'(trial - {1'b0, dsr_ff}) : trial[SUM_WIDTH-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
